### sv/assert_macros.svh
// Assertion macros shared by the lexer RTL.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Check that cond never holds at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### sv/atl_pkg.sv
// Types, widths and character constants of the assembly token lexer.
// Used by every module of the lexer; depends on nothing.
package atl_pkg;

  localparam int unsigned LINE_BITS  = 16;
  localparam int unsigned LINE_OUT_W = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned KEEP_BYTES = 4;
  localparam int unsigned NUM_WORDS  = 5;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_INSTR  = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  // Instruction words; the row index is the instruction code
  // (push, add, sub, mul, hlt).
  localparam logic [BYTE_W-1:0] WORD_TEXT [NUM_WORDS][KEEP_BYTES] = '{
    '{8'h70, 8'h75, 8'h73, 8'h68},
    '{8'h61, 8'h64, 8'h64, 8'h00},
    '{8'h73, 8'h75, 8'h62, 8'h00},
    '{8'h6D, 8'h75, 8'h6C, 8'h00},
    '{8'h68, 8'h6C, 8'h74, 8'h00}
  };
  localparam logic [LEN_W-1:0] WORD_LEN [NUM_WORDS] = '{
    4'd4, 4'd3, 4'd3, 4'd3, 4'd3
  };

  typedef struct packed {
    kind_e                 kind;
    logic [VALUE_W-1:0]    value;
    logic [LINE_OUT_W-1:0] line;
    logic                  at_end;
  } token_t;

  typedef struct packed {
    logic             valid;
    logic [BYTE_W-1:0] data;
  } stage_t;

  typedef struct packed {
    logic err;
    logic line_one;
  } core_status_t;

endpackage

### sv/atl_in_reg.sv
// Input register of the lexer: holds one accepted source byte.
// Depends on atl_pkg.
module atl_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [atl_pkg::BYTE_W-1:0] source_byte_i,
  input  logic                      advance_i,
  output atl_pkg::stage_t           stage_o
);

  logic                       valid_q, valid_d;
  logic [atl_pkg::BYTE_W-1:0] data_q;

  // Free when empty or when the held item moves on this cycle.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= source_byte_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

### sv/atl_core.sv
// Lexer state and token decision for one source byte per cycle in which step_i is high.
// Depends on atl_pkg.
module atl_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [atl_pkg::BYTE_W-1:0] byte_i,
  output logic                       res_valid_o,
  output atl_pkg::token_t            res_o,
  output atl_pkg::core_status_t      status_o
);

  logic [atl_pkg::LEN_W-1:0]     len_q, len_d;
  logic [atl_pkg::BYTE_W-1:0]    bytes_q [atl_pkg::KEEP_BYTES];
  logic [atl_pkg::BYTE_W-1:0]    bytes_d [atl_pkg::KEEP_BYTES];
  logic [atl_pkg::VALUE_W-1:0]   acc_q, acc_d;
  logic                          neg_q, neg_d;
  logic                          stop_q, stop_d;
  logic [atl_pkg::LINE_BITS-1:0] line_q, line_d;
  logic                          err_q, err_d;

  logic                          delim;
  logic                          is_digit;
  logic                          is_number;
  logic                          word_hit;
  logic [atl_pkg::VALUE_W-1:0]   word_code;
  logic [atl_pkg::LINE_BITS-1:0] line_inc;

  assign delim = (byte_i == atl_pkg::CHAR_SPACE) || (byte_i == atl_pkg::CHAR_TAB) ||
                 (byte_i == atl_pkg::CHAR_NL)    || (byte_i == atl_pkg::CHAR_NUL);
  assign is_digit  = (byte_i >= atl_pkg::CHAR_ZERO) && (byte_i <= atl_pkg::CHAR_NINE);
  assign is_number = (bytes_q[0] == atl_pkg::CHAR_HASH);
  assign line_inc  = (line_q == '1) ? line_q : line_q + 1'b1;

  // Compare the held lexeme with every instruction word; lowest code wins.
  always_comb begin
    word_hit  = 1'b0;
    word_code = '0;
    for (int w = atl_pkg::NUM_WORDS - 1; w >= 0; w--) begin
      if ((len_q == atl_pkg::WORD_LEN[w]) &&
          (bytes_q[0] == atl_pkg::WORD_TEXT[w][0]) &&
          (bytes_q[1] == atl_pkg::WORD_TEXT[w][1]) &&
          (bytes_q[2] == atl_pkg::WORD_TEXT[w][2]) &&
          ((atl_pkg::WORD_LEN[w] < 4'd4) || (bytes_q[3] == atl_pkg::WORD_TEXT[w][3]))) begin
        word_hit  = 1'b1;
        word_code = atl_pkg::VALUE_W'(w);
      end
    end
  end

  always_comb begin
    len_d   = len_q;
    bytes_d = bytes_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    stop_d  = stop_q;
    line_d  = line_q;
    err_d   = err_q;

    res_valid_o   = 1'b0;
    res_o.kind    = atl_pkg::KIND_END;
    res_o.value   = '0;
    res_o.line    = atl_pkg::LINE_OUT_W'(line_q);
    res_o.at_end  = 1'b0;

    if (step_i) begin
      if (err_q) begin
        // Drop everything until end of source.
        if (byte_i == atl_pkg::CHAR_NUL) begin
          res_valid_o  = 1'b1;
          res_o.at_end = 1'b1;
        end
      end else if (!delim) begin
        if (len_q < atl_pkg::LEN_W'(atl_pkg::KEEP_BYTES)) begin
          bytes_d[len_q[1:0]] = byte_i;
        end
        if ((len_q != '0) && is_number && !stop_q) begin
          if ((len_q == 4'd1) &&
              ((byte_i == atl_pkg::CHAR_PLUS) || (byte_i == atl_pkg::CHAR_MINUS))) begin
            neg_d = (byte_i == atl_pkg::CHAR_MINUS);
          end else if (is_digit) begin
            acc_d = (acc_q << 3) + (acc_q << 1) +
                    atl_pkg::VALUE_W'(byte_i - atl_pkg::CHAR_ZERO);
          end else begin
            stop_d = 1'b1;
          end
        end
        if (len_q != atl_pkg::LEN_MAX) begin
          len_d = len_q + 1'b1;
        end
      end else if (len_q == '0) begin
        if (byte_i == atl_pkg::CHAR_NUL) begin
          res_valid_o  = 1'b1;
          res_o.at_end = 1'b1;
        end else if (byte_i == atl_pkg::CHAR_NL) begin
          line_d = line_inc;
        end
      end else begin
        res_valid_o  = 1'b1;
        res_o.at_end = (byte_i == atl_pkg::CHAR_NUL);
        if (is_number) begin
          res_o.kind  = atl_pkg::KIND_NUMBER;
          res_o.value = neg_q ? ('0 - acc_q) : acc_q;
        end else if (word_hit) begin
          res_o.kind  = atl_pkg::KIND_INSTR;
          res_o.value = word_code;
        end else begin
          res_o.kind = atl_pkg::KIND_ERROR;
          err_d      = 1'b1;
        end
        len_d  = '0;
        acc_d  = '0;
        neg_d  = 1'b0;
        stop_d = 1'b0;
        if (is_number || word_hit) begin
          if (byte_i == atl_pkg::CHAR_NL) begin
            line_d = line_inc;
          end
        end
      end

      // End of source restarts the lexer.
      if (byte_i == atl_pkg::CHAR_NUL) begin
        len_d  = '0;
        acc_d  = '0;
        neg_d  = 1'b0;
        stop_d = 1'b0;
        line_d = atl_pkg::LINE_BITS'(1);
        err_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      stop_q <= 1'b0;
      line_q <= atl_pkg::LINE_BITS'(1);
      err_q  <= 1'b0;
    end else begin
      len_q  <= len_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      stop_q <= stop_d;
      line_q <= line_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign status_o.err      = err_q;
  assign status_o.line_one = (line_q == atl_pkg::LINE_BITS'(1));

endmodule

### sv/atl_out_reg.sv
// Result register of the lexer: holds one token until the consumer takes it.
// Depends on atl_pkg.
module atl_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  atl_pkg::token_t token_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output atl_pkg::token_t token_o
);

  logic            valid_q, valid_d;
  atl_pkg::token_t token_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      token_q <= token_i;
    end
  end

  assign out_valid_o = valid_q;
  assign token_o     = token_q;

endmodule

### sv/assembly_token_lexer_top.sv
// Top level of the assembly token lexer: input register, lexer core, result register.
// Depends on atl_pkg, atl_in_reg, atl_core, atl_out_reg and assert_macros.svh.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   input    | in_valid_i/in_ready_o | source_byte_i[7:0]
//   result   | out_valid_o/out_ready_i| token_kind_o, token_value_o, line_number_o,
//            |                       | at_end_o
//
// One byte per cycle unless the result stalls: a byte held in the input register is lexed
// as it advances; its token, if any, is registered with the state update. The single
// lexer-state update per byte sets the rate. Reset clears the lexeme, the error flag
// and sets the line counter to 1. A stalled result holds the core; the input register
// then fills and in_ready_o drops, taking again in the same cycle the result is taken.
`include "assert_macros.svh"

module assembly_token_lexer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [atl_pkg::BYTE_W-1:0]     source_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     token_kind_o,
  output logic [atl_pkg::VALUE_W-1:0]    token_value_o,
  output logic [atl_pkg::LINE_OUT_W-1:0] line_number_o,
  output logic                           at_end_o
);

  atl_pkg::stage_t       stage;
  atl_pkg::token_t       res;
  atl_pkg::token_t       shown;
  atl_pkg::core_status_t status;
  logic                  res_valid;
  logic                  out_free;
  logic                  advance;

  // Advance the held byte whenever the result register can take its token.
  assign advance = stage.valid && out_free;

  atl_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .source_byte_i (source_byte_i),
    .advance_i     (advance),
    .stage_o       (stage)
  );

  // Lex the byte; state moves only on an advancing cycle.
  atl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (stage.data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  atl_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .token_i     (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .token_o     (shown)
  );

  assign token_kind_o  = shown.kind;
  assign token_value_o = shown.value;
  assign line_number_o = shown.line;
  assign at_end_o      = shown.at_end;

  // End of source restarts the line count and clears error mode.
  `ASSERT_PROP(a_end_restarts, clk_i, rst_ni, (advance && res_valid && res.at_end) |=> (status.line_one && !status.err))
  // In error mode only an end-of-source result may appear.
  `ASSERT_PROP(a_err_only_end, clk_i, rst_ni, (status.err && res_valid) |-> (res.at_end && (res.kind == atl_pkg::KIND_END)))
  // A syntax error not at end of source enters error mode.
  `ASSERT_PROP(a_err_enters, clk_i, rst_ni, (advance && res_valid && (res.kind == atl_pkg::KIND_ERROR) && !res.at_end) |=> status.err)
  // Line numbers start at one and never wrap to zero.
  `ASSERT_NEVER(a_line_nonzero, clk_i, rst_ni, out_valid_o && (line_number_o == '0))

endmodule

### bench/token_stream_checker.sv
// Token checker for the assembly token lexer: predicts the token stream from the accepted bytes
// and compares it with the result channel. Depends on atl_pkg.
module token_stream_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [atl_pkg::BYTE_W-1:0]     source_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [1:0]                     token_kind_i,
  input  logic [atl_pkg::VALUE_W-1:0]    token_value_i,
  input  logic [atl_pkg::LINE_OUT_W-1:0] line_number_i,
  input  logic                           at_end_i,
  output int                             mismatches_o,
  output int                             tokens_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_HLT} opcode_e;

  // Row index is the instruction code.
  string mnemonic [OP_HLT + 1] = '{"push", "add", "sub", "mul", "hlt"};

  logic [atl_pkg::LEN_W-1:0]     lex_len;
  logic [atl_pkg::BYTE_W-1:0]    lex_head [atl_pkg::KEEP_BYTES];
  logic [atl_pkg::VALUE_W-1:0]   num_acc;
  logic                          num_neg;
  logic                          num_stopped;
  logic                          in_error;
  logic [atl_pkg::LINE_BITS-1:0] line_cnt;

  atl_pkg::token_t tokens_due [$];
  int              mismatches;

  assign mismatches_o = mismatches;

  function automatic void clear_lexeme();
    lex_len     = '0;
    lex_head    = '{default: '0};
    num_acc     = '0;
    num_neg     = 1'b0;
    num_stopped = 1'b0;
  endfunction

  function automatic void restart();
    clear_lexeme();
    line_cnt = atl_pkg::LINE_BITS'(1);
    in_error = 1'b0;
  endfunction

  function automatic void advance_line();
    if (line_cnt != '1) line_cnt++;
  endfunction

  // Advance the lexer by one byte; return 1 when the byte closes a token.
  function automatic bit lex_byte(input logic [atl_pkg::BYTE_W-1:0] b,
                                  output atl_pkg::token_t tok);
    logic delim;
    logic hit;
    int   code;
    delim = (b == atl_pkg::CHAR_SPACE) || (b == atl_pkg::CHAR_TAB) ||
            (b == atl_pkg::CHAR_NL) || (b == atl_pkg::CHAR_NUL);
    tok = '0;
    tok.line   = atl_pkg::LINE_OUT_W'(line_cnt);
    tok.at_end = (b == atl_pkg::CHAR_NUL);
    if (in_error) begin
      if (b != atl_pkg::CHAR_NUL) return 1'b0;
      tok.kind = atl_pkg::KIND_END;
      restart();
      return 1'b1;
    end
    if (!delim) begin
      if (lex_len < atl_pkg::KEEP_BYTES) lex_head[lex_len] = b;
      if (lex_len != 0 && lex_head[0] == atl_pkg::CHAR_HASH && !num_stopped) begin
        if (lex_len == 1 && (b == atl_pkg::CHAR_PLUS || b == atl_pkg::CHAR_MINUS)) begin
          num_neg = (b == atl_pkg::CHAR_MINUS);
        end else if (b >= atl_pkg::CHAR_ZERO && b <= atl_pkg::CHAR_NINE) begin
          num_acc = num_acc * 10 + atl_pkg::VALUE_W'(b - atl_pkg::CHAR_ZERO);
        end else begin
          num_stopped = 1'b1;
        end
      end
      if (lex_len != atl_pkg::LEN_MAX) lex_len++;
      return 1'b0;
    end
    if (lex_len == 0) begin
      if (b == atl_pkg::CHAR_NUL) begin
        tok.kind = atl_pkg::KIND_END;
        restart();
        return 1'b1;
      end
      if (b == atl_pkg::CHAR_NL) advance_line();
      return 1'b0;
    end
    if (lex_head[0] == atl_pkg::CHAR_HASH) begin
      tok.kind  = atl_pkg::KIND_NUMBER;
      tok.value = num_neg ? -num_acc : num_acc;
    end else begin
      code = -1;
      for (int w = OP_PUSH; w <= OP_HLT; w++) begin
        hit = (code < 0) && (lex_len == mnemonic[w].len());
        for (int i = 0; i < mnemonic[w].len(); i++)
          if (lex_head[i] != mnemonic[w][i]) hit = 1'b0;
        if (hit) code = w;
      end
      if (code >= 0) begin
        tok.kind  = atl_pkg::KIND_INSTR;
        tok.value = atl_pkg::VALUE_W'(code);
      end else begin
        tok.kind = atl_pkg::KIND_ERROR;
      end
    end
    if (b == atl_pkg::CHAR_NUL) begin
      restart();
    end else begin
      // An unknown word silences the rest of the source; its delimiter counts no line.
      if (tok.kind == atl_pkg::KIND_ERROR) in_error = 1'b1;
      else if (b == atl_pkg::CHAR_NL) advance_line();
      clear_lexeme();
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string field, logic [atl_pkg::VALUE_W-1:0] want,
                                      logic [atl_pkg::VALUE_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, seen);
      mismatches++;
    end
  endfunction

  // Results come from bytes taken at earlier edges, so compare before predicting.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    atl_pkg::token_t want;
    atl_pkg::token_t fresh;
    if (!rst_ni) begin
      restart();
      tokens_due.delete();
      tokens_due_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: result expected none, actual kind %0d value %0d line %0d end %0b",
                   $time, token_kind_i, token_value_i, line_number_i, at_end_i);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", atl_pkg::VALUE_W'(want.kind),
                      atl_pkg::VALUE_W'(token_kind_i));
          check_field("token_value", want.value, token_value_i);
          check_field("line_number", atl_pkg::VALUE_W'(want.line),
                      atl_pkg::VALUE_W'(line_number_i));
          check_field("at_end", atl_pkg::VALUE_W'(want.at_end), atl_pkg::VALUE_W'(at_end_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (lex_byte(source_byte_i, fresh)) tokens_due.push_back(fresh);
      end
      tokens_due_o <= tokens_due.size();
    end
  end

endmodule

### bench/assembly_token_lexer_top_tb.sv
// Testbench top for the assembly token lexer: clock, reset, byte stimulus, receiver stalls,
// watchdog and verdict. Depends on atl_pkg, assembly_token_lexer_top and token_stream_checker.
module assembly_token_lexer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The longest stretch with no item moving is the receiver hold-off plus its drain;
  // the watchdog limit leaves a wide margin over it.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_OFF     = 400;
  localparam int DRAIN        = 16;
  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_TAIL   = 300;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [atl_pkg::BYTE_W-1:0]     source_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic [1:0]                     token_kind;
  logic [atl_pkg::VALUE_W-1:0]    token_value;
  logic [atl_pkg::LINE_OUT_W-1:0] line_number;
  logic                           at_end;

  int mismatches;
  int tokens_due;
  int sent_count    = 0;
  int pressure_at   = 32'h7fff_ffff;
  bit pressure_done = 1'b0;
  bit quiet         = 1'b0;
  int stall_cycles  = 0;

  string mnemonic [5] = '{"push", "add", "sub", "mul", "hlt"};

  assembly_token_lexer_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .source_byte_i (source_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .token_kind_o  (token_kind),
    .token_value_o (token_value),
    .line_number_o (line_number),
    .at_end_o      (at_end)
  );

  token_stream_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .source_byte_i (source_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .token_kind_i  (token_kind),
    .token_value_i (token_value),
    .line_number_i (line_number),
    .at_end_i      (at_end),
    .mismatches_o  (mismatches),
    .tokens_due_o  (tokens_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one byte and hold it until taken. An optional idle burst goes first, so the
  // drop of valid and its rise never share a time step.
  task automatic send_byte(input logic [atl_pkg::BYTE_W-1:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    source_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Any byte that is neither a delimiter nor the end-of-source byte.
  function automatic logic [atl_pkg::BYTE_W-1:0] random_glyph();
    logic [atl_pkg::BYTE_W-1:0] g;
    do g = atl_pkg::BYTE_W'($urandom_range(1, 255));
    while (g == atl_pkg::CHAR_TAB || g == atl_pkg::CHAR_NL || g == atl_pkg::CHAR_SPACE);
    return g;
  endfunction

  // One lexeme: mostly valid words and numbers, some near-miss words and plain noise.
  task automatic send_lexeme();
    string                      w;
    logic [atl_pkg::BYTE_W-1:0] tail;
    int                         pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_text(mnemonic[$urandom_range(0, 4)]);
    end else if (pick < 86) begin
      send_byte(atl_pkg::CHAR_HASH);
      case ($urandom_range(0, 3))
        1: send_byte(atl_pkg::CHAR_PLUS);
        2: send_byte(atl_pkg::CHAR_MINUS);
        default: ;
      endcase
      // Long digit runs wrap the 32-bit value.
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 20) : $urandom_range(0, 5))
        send_byte(atl_pkg::CHAR_ZERO + atl_pkg::BYTE_W'($urandom_range(0, 9)));
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) send_byte(random_glyph());
    end else if (pick < 95) begin
      w    = mnemonic[$urandom_range(0, 4)];
      tail = atl_pkg::CHAR_NUL;
      case ($urandom_range(0, 3))
        0: w = w.substr(0, w.len() - 2);
        // extra lower-case letter
        1: tail = atl_pkg::BYTE_W'($urandom_range(8'h61, 8'h7a));
        2: w.putc($urandom_range(0, w.len() - 1),
                  atl_pkg::BYTE_W'($urandom_range(8'h61, 8'h7a)));
        default: w = w.toupper();
      endcase
      send_text(w);
      if (tail != atl_pkg::CHAR_NUL) send_byte(tail);
    end else begin
      repeat ($urandom_range(1, 18)) send_byte(random_glyph());
    end
  endtask

  // One or more delimiters; runs of them give empty lexemes.
  task automatic send_gap();
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1) begin
      case ($urandom_range(0, 2))
        0: send_byte(atl_pkg::CHAR_SPACE);
        1: send_byte(atl_pkg::CHAR_TAB);
        default: send_byte(atl_pkg::CHAR_NL);
      endcase
    end
  endtask

  // A whole source: lexemes with gaps, closed by the end-of-source byte, sometimes
  // straight after the last lexeme.
  task automatic send_program();
    int n;
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      send_lexeme();
      if (i < n - 1 || $urandom_range(0, 1) == 1) send_gap();
    end
    send_byte(atl_pkg::CHAR_NUL);
  endtask

  // Stimulus: reset, directed sources, then random sources.
  initial begin : stimulus
    int target;
    in_valid    <= 1'b0;
    source_byte <= atl_pkg::CHAR_NUL;
    rst_n       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Every instruction, with each kind of delimiter; the last one closed by the end byte.
    send_text("push add\tsub\nmul hlt");
    send_byte(atl_pkg::CHAR_NUL);
    // Number corners: largest value, negation, explicit plus, bare hash, sign only,
    // digits stopped by a letter, sign not directly after the hash, wrap past 32 bits.
    send_text("#4294967295 #-1 #+0 # #- #12ab34 #+-5\n#12345678901234567890");
    send_byte(atl_pkg::CHAR_NUL);
    // Empty lexemes only, then an end byte on an empty source.
    send_text("  \t\n\n");
    send_byte(atl_pkg::CHAR_NUL);
    send_byte(atl_pkg::CHAR_NUL);
    // An over-long lexeme is unknown, so the good and unknown words after it are ignored until the end.
    send_text("pushpushpushpushpush hlt pusha add\n");
    send_byte(8'hFF);
    send_byte(atl_pkg::CHAR_NUL);
    // Top-bit bytes as an unknown lexeme.
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(atl_pkg::CHAR_SPACE);
    send_byte(atl_pkg::CHAR_NUL);
    // Unknown lexeme closed by the end byte, then upper case, which silences the number closed by the end byte.
    send_text("xyz");
    send_byte(atl_pkg::CHAR_NUL);
    send_text("\n\nHLT\n#-7");
    send_byte(atl_pkg::CHAR_NUL);

    // Random sources; arm the receiver hold-off part way in, and drop idling at the tail.
    pressure_at = sent_count + 500;
    target      = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      if (sent_count >= target - QUIET_TAIL) quiet = 1'b1;
      send_program();
    end
    in_valid <= 1'b0;

    while (tokens_due != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && tokens_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off to fill the block, none at the tail.
  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!pressure_done && sent_count >= pressure_at) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
